[hw/rtl/qst_pkg.sv]
// Package for the query string tokenizer: size limits, parser phase codes,
// result kinds and the result record type. Depends on nothing.
package qst_pkg;

    localparam int MAX_PAIRS = 64;
    localparam int MAX_LEN   = 4096;

    localparam int BYTE_W  = 8;
    localparam int LIMIT_W = 7;
    localparam int START_W = 12;
    localparam int LEN_W   = 13;
    localparam int COUNT_W = 7;
    localparam int KIND_W  = 2;
    localparam int DATA_W  = 40;
    localparam int SLOTS   = 3;

    localparam logic [BYTE_W-1:0]  CHAR_EQ  = 8'h3D;
    localparam logic [BYTE_W-1:0]  CHAR_AMP = 8'h26;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    localparam logic [KIND_W-1:0] KIND_KEY     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VALUE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

    typedef enum logic [3:0] {
        PH_KEY_START   = 4'b0001,
        PH_KEY         = 4'b0010,
        PH_VALUE_START = 4'b0100,
        PH_VALUE       = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [START_W-1:0] span_start;
        logic [LEN_W-1:0]   span_length;
        logic               present;
        logic [COUNT_W-1:0] pair_count;
        logic               status;
    } result_t;

    function automatic result_t make_result(
        input logic [KIND_W-1:0]  kind,
        input logic [START_W-1:0] span_start,
        input logic [LEN_W-1:0]   span_length,
        input logic               present,
        input logic [COUNT_W-1:0] pair_count,
        input logic               status
    );
        result_t r;
        r.kind        = kind;
        r.span_start  = span_start;
        r.span_length = span_length;
        r.present     = present;
        r.pair_count  = pair_count;
        r.status      = status;
        return r;
    endfunction

endpackage

[hw/rtl/query_string_tokenizer.sv]
// Top level of the query string tokenizer: parses key=value&key=value bytes
// into key and value spans and an end-of-string summary. Depends on qst_pkg.

// One byte is taken per cycle. A byte that gives no result leaves the input
// ready in the next cycle; a byte that gives a single result does so when the
// receiver takes that result in that cycle. A byte that gives two or three
// results (a key closed by '&', the end of the string, or a pair limit
// overflow) holds the input while its results leave the three-slot result
// buffer at one item per cycle as the receiver takes them. A receiver that
// holds off stalls the input for as long as a result waits. The parse of a
// byte is done in the cycle it is accepted and lands directly in that
// buffer, so results appear in the cycle after their byte at the earliest.
module query_string_tokenizer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wen,
    input  logic [qst_pkg::LIMIT_W-1:0] cfg_wdata,   // pair_limit
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [qst_pkg::BYTE_W-1:0]  s_tdata,     // byte_in[7:0]
    input  logic                      s_tlast,       // final_byte
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // span_start[11:0], span_length[24:12], present[25], pair_count[32:26],
    // status[33], zero fill[39:34]
    output logic [qst_pkg::DATA_W-1:0]  m_tdata,
    output logic [qst_pkg::KIND_W-1:0]  m_tuser,     // kind[1:0]
    output logic                      m_tlast        // last
);
    import qst_pkg::*;

    localparam int EW = $clog2(2 * MAX_PAIRS + 1);
    localparam int PW = $clog2(MAX_LEN + 1);
    localparam int TW = $clog2(MAX_LEN);
    localparam int LW = EW + LIMIT_W;

    logic [LIMIT_W-1:0] pair_limit_reg;
    phase_t             phase_reg, phase_next;
    logic [PW-1:0]      position_reg, position_next;
    logic [TW-1:0]      begin_reg, begin_next;
    logic [EW-1:0]      entry_reg, entry_next;
    logic               stopped_reg, stopped_next;

    result_t            slot_reg [SLOTS];
    result_t            slot_new [SLOTS];
    logic [1:0]         count_reg, count_new;

    logic               in_fire, out_fire, sep, over;
    logic [LW-1:0]      limit_eff;
    logic [TW-1:0]      begin_clamped;
    result_t            absent_r;

    assign sep      = (s_tdata == CHAR_EQ) || (s_tdata == CHAR_AMP);
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign s_tready = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_tready);

    assign begin_clamped = (position_reg < PW'(MAX_LEN)) ? TW'(position_reg)
                                                         : TW'(MAX_LEN - 1);

    always_comb
    begin
        limit_eff = LW'(pair_limit_reg);
        if (limit_eff == '0)
        begin
            limit_eff = LW'(1);
        end
        else if (limit_eff > LW'(MAX_PAIRS))
        begin
            limit_eff = LW'(MAX_PAIRS);
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        position_next = position_reg;
        begin_next    = begin_reg;
        entry_next    = entry_reg;
        stopped_next  = stopped_reg;
        over          = 1'b0;
        count_new     = 2'd0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_new[i] = '0;
        end
        absent_r = '0;

        if (stopped_reg)
        begin
            if (s_tlast)
            begin
                stopped_next  = 1'b0;
                phase_next    = PH_KEY_START;
                position_next = '0;
                begin_next    = '0;
                entry_next    = '0;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_KEY_START:
                begin
                    if (!sep)
                    begin
                        begin_next = begin_clamped;
                        phase_next = PH_KEY;
                    end
                end
                PH_KEY:
                begin
                    if (sep)
                    begin
                        entry_next = entry_next + EW'(1);
                        slot_new[count_new] = make_result(KIND_KEY, START_W'(begin_reg),
                            LEN_W'(position_reg - PW'(begin_reg)), 1'b1,
                            COUNT_W'(entry_next[EW-1:1]), 1'b0);
                        count_new = count_new + 2'd1;
                        if (s_tdata == CHAR_EQ)
                        begin
                            phase_next = PH_VALUE_START;
                        end
                        else
                        begin
                            entry_next = entry_next + EW'(1);
                            absent_r = '0;
                            absent_r.kind = KIND_VALUE;
                            absent_r.pair_count = COUNT_W'(entry_next[EW-1:1]);
                            slot_new[count_new] = absent_r;
                            count_new = count_new + 2'd1;
                            over = LW'(entry_next[EW-1:1]) >= limit_eff;
                            phase_next = PH_KEY_START;
                        end
                    end
                end
                PH_VALUE_START:
                begin
                    if (sep)
                    begin
                        entry_next = entry_next + EW'(1);
                        absent_r = '0;
                        absent_r.kind = KIND_VALUE;
                        absent_r.pair_count = COUNT_W'(entry_next[EW-1:1]);
                        slot_new[count_new] = absent_r;
                        count_new = count_new + 2'd1;
                        over = LW'(entry_next[EW-1:1]) >= limit_eff;
                        phase_next = PH_KEY_START;
                    end
                    else
                    begin
                        begin_next = begin_clamped;
                        phase_next = PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    if (s_tdata == CHAR_AMP)
                    begin
                        entry_next = entry_next + EW'(1);
                        slot_new[count_new] = make_result(KIND_VALUE, START_W'(begin_reg),
                            LEN_W'(position_reg - PW'(begin_reg)), 1'b1,
                            COUNT_W'(entry_next[EW-1:1]), 1'b0);
                        count_new = count_new + 2'd1;
                        over = LW'(entry_next[EW-1:1]) >= limit_eff;
                        phase_next = PH_KEY_START;
                    end
                end
                default:
                begin
                    phase_next = PH_KEY_START;
                end
            endcase

            position_next = (position_reg < PW'(MAX_LEN)) ? position_reg + PW'(1)
                                                          : PW'(MAX_LEN);

            if (over || s_tlast)
            begin
                if (!over)
                begin
                    unique case (phase_next)
                        PH_KEY:
                        begin
                            entry_next = entry_next + EW'(1);
                            slot_new[count_new] = make_result(KIND_KEY,
                                START_W'(begin_next),
                                LEN_W'(position_next - PW'(begin_next)), 1'b1,
                                COUNT_W'(entry_next[EW-1:1]), 1'b0);
                            count_new = count_new + 2'd1;
                            entry_next = entry_next + EW'(1);
                            absent_r = '0;
                            absent_r.kind = KIND_VALUE;
                            absent_r.pair_count = COUNT_W'(entry_next[EW-1:1]);
                            slot_new[count_new] = absent_r;
                            count_new = count_new + 2'd1;
                        end
                        PH_VALUE_START:
                        begin
                            entry_next = entry_next + EW'(1);
                            absent_r = '0;
                            absent_r.kind = KIND_VALUE;
                            absent_r.pair_count = COUNT_W'(entry_next[EW-1:1]);
                            slot_new[count_new] = absent_r;
                            count_new = count_new + 2'd1;
                        end
                        PH_VALUE:
                        begin
                            entry_next = entry_next + EW'(1);
                            slot_new[count_new] = make_result(KIND_VALUE,
                                START_W'(begin_next),
                                LEN_W'(position_next - PW'(begin_next)), 1'b1,
                                COUNT_W'(entry_next[EW-1:1]), 1'b0);
                            count_new = count_new + 2'd1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                slot_new[count_new] = make_result(KIND_SUMMARY, '0, '0, 1'b0,
                    COUNT_W'(entry_next[EW-1:1]), over);
                count_new = count_new + 2'd1;
                stopped_next  = over && !s_tlast;
                phase_next    = PH_KEY_START;
                position_next = '0;
                begin_next    = '0;
                entry_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_limit_reg <= LIMIT_RESET;
            phase_reg      <= PH_KEY_START;
            position_reg   <= '0;
            begin_reg      <= '0;
            entry_reg      <= '0;
            stopped_reg    <= 1'b0;
            count_reg      <= 2'd0;
        end
        else
        begin
            if (cfg_wen)
            begin
                pair_limit_reg <= cfg_wdata;
            end
            if (in_fire)
            begin
                phase_reg    <= phase_next;
                position_reg <= position_next;
                begin_reg    <= begin_next;
                entry_reg    <= entry_next;
                stopped_reg  <= stopped_next;
                count_reg    <= count_new;
            end
            else if (out_fire)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_reg[i] <= slot_new[i];
            end
        end
        else if (out_fire)
        begin
            for (int i = 0; i < SLOTS - 1; i++)
            begin
                slot_reg[i] <= slot_reg[i + 1];
            end
        end
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tlast  = (count_reg == 2'd1);
    assign m_tuser  = slot_reg[0].kind;
    assign m_tdata  = {6'b0, slot_reg[0].status, slot_reg[0].pair_count,
                       slot_reg[0].present, slot_reg[0].span_length,
                       slot_reg[0].span_start};

endmodule
